// ===== sv/heartbeat_liveness_table_defines.svh =====
// Assertion macros for the heartbeat liveness table.
// Included by the modules that assert; needs aclk and aresetn in scope.
`ifndef HEARTBEAT_LIVENESS_TABLE_DEFINES_SVH
`define HEARTBEAT_LIVENESS_TABLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HLT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HLT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/hlt_pkg.sv =====
// Shared types and codes for the heartbeat liveness table.
// No dependencies; used by hlt_ctrl, hlt_datapath and the top level.
package hlt_pkg;

    localparam int NODE_SLOTS_DEFAULT = 32;
    localparam logic [7:0] RELOAD_RESET = 8'd5;

    // Request kinds (s_tuser)
    localparam logic [1:0] REQ_HEARTBEAT = 2'd0;
    localparam logic [1:0] REQ_TICK      = 2'd1;
    localparam logic [1:0] REQ_REGISTER  = 2'd2;

    // Result status (m_tuser)
    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_NOT_REG  = 2'd1;
    localparam logic [1:0] ST_DIED     = 2'd2;
    localparam logic [1:0] ST_DONE     = 2'd3;

    // Controller -> datapath commands
    typedef struct packed {
        logic item_go;      // heartbeat or register transaction taken
        logic sweep_start;  // tick taken, rewind sweep pointer
        logic slot_kill;    // remove current slot, post died result
        logic slot_dec;     // decrement current slot count
        logic slot_skip;    // current slot not live
        logic emit_done;    // post sweep done result
    } cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic out_free;     // output register can take a result this cycle
        logic slot_live;    // current sweep slot is live
        logic cnt_zero;     // current sweep slot count is zero
        logic last_slot;    // sweep pointer at the final slot
    } stat_t;

endpackage

// ===== sv/hlt_ctrl.sv =====
// Sweep and request controller for the heartbeat liveness table.
// Depends on hlt_pkg and heartbeat_liveness_table_defines.svh.
`include "heartbeat_liveness_table_defines.svh"

module hlt_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    input  logic [1:0]     req_type,
    output logic           in_ready,
    input  hlt_pkg::stat_t stat,
    output hlt_pkg::cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       advance;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE) && stat.out_free;
        advance    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    if (req_type == hlt_pkg::REQ_TICK) begin
                        cmd.sweep_start = 1'b1;
                        state_next      = S_READ;
                    end else if (req_type == hlt_pkg::REQ_HEARTBEAT ||
                                 req_type == hlt_pkg::REQ_REGISTER) begin
                        cmd.item_go = 1'b1;
                    end
                end
            end
            S_READ: begin
                // count read in flight
                state_next = S_EVAL;
            end
            S_EVAL: begin
                priority if (!stat.slot_live) begin
                    cmd.slot_skip = 1'b1;
                end else if (stat.cnt_zero) begin
                    cmd.slot_kill = stat.out_free;
                end else begin
                    cmd.slot_dec = 1'b1;
                end
                advance = cmd.slot_skip || cmd.slot_kill || cmd.slot_dec;
                if (advance) begin
                    state_next = stat.last_slot ? S_DONE : S_READ;
                end
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.emit_done = 1'b1;
                    state_next    = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `HLT_ASSERT_IMPL(a_ready_idle, in_ready, state_reg == S_IDLE, "ready outside idle")
    `HLT_ASSERT_IMPL(a_kill_free, cmd.slot_kill, stat.out_free, "died result with output full")
    `HLT_ASSERT_NEXT(a_tick_sweeps, cmd.sweep_start, state_reg == S_READ, "tick did not start sweep")
    `HLT_ASSERT_NEXT(a_stall_holds,
        state_reg == S_EVAL && stat.slot_live && stat.cnt_zero && !stat.out_free,
        state_reg == S_EVAL, "stalled kill left slot")

endmodule

// ===== sv/hlt_datapath.sv =====
// Datapath for the heartbeat liveness table: live flags, count memory,
// sweep pointer, reload register and output register. Depends on hlt_pkg.
module hlt_datapath #(
    parameter int NODE_SLOTS = hlt_pkg::NODE_SLOTS_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [7:0]     cfg_wr_data,
    input  logic [1:0]     req_type,
    input  logic [4:0]     node_id,
    input  hlt_pkg::cmd_t  cmd,
    output hlt_pkg::stat_t stat,
    input  logic           out_ready,
    output logic           out_valid,
    output logic [1:0]     out_status,
    output logic [4:0]     out_node,
    output logic           out_last
);

    localparam int SLOT_W = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;

    logic [7:0]            reload_reg;
    logic [NODE_SLOTS-1:0] live_reg;
    logic [NODE_SLOTS-1:0] live_next;
    logic [SLOT_W-1:0]     idx_reg;
    logic [SLOT_W-1:0]     idx_next;
    logic [7:0]            cnt_mem [NODE_SLOTS];
    logic [7:0]            rd_data_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [1:0]        out_status_reg;
    logic [4:0]        out_node_reg;
    logic              out_last_reg;
    logic              out_load;
    logic [1:0]        res_status;
    logic [4:0]        res_node;
    logic              res_last;

    logic              id_ok;
    logic [5:0]        id_wide;
    logic [SLOT_W-1:0] hb_idx;
    logic              hb_live;
    logic              item_ok;
    logic [5:0]        idx_wide;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    assign id_wide  = {1'b0, node_id};
    assign id_ok    = {2'b00, node_id} < 7'(NODE_SLOTS);
    assign hb_idx   = id_wide[SLOT_W-1:0];
    assign hb_live  = live_reg[hb_idx];
    assign idx_wide = 6'(idx_reg);

    // heartbeat needs a live slot, register only a slot in range
    assign item_ok = id_ok && ((req_type == hlt_pkg::REQ_REGISTER) || hb_live);

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.slot_live = live_reg[idx_reg];
    assign stat.cnt_zero  = (rd_data_reg == 8'd0);
    assign stat.last_slot = (idx_reg == SLOT_W'(NODE_SLOTS - 1));

    always_comb begin
        live_next = live_reg;
        if (cmd.item_go && id_ok && (req_type == hlt_pkg::REQ_REGISTER)) begin
            live_next[hb_idx] = 1'b1;
        end
        if (cmd.slot_kill) begin
            live_next[idx_reg] = 1'b0;
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.sweep_start) begin
            idx_next = '0;
        end else if (cmd.slot_kill || cmd.slot_dec || cmd.slot_skip) begin
            idx_next = idx_reg + SLOT_W'(1);
        end
    end

    // single write port: sweep decrement or reload
    assign wr_en   = cmd.slot_dec || (cmd.item_go && item_ok);
    assign wr_addr = cmd.slot_dec ? idx_reg : hb_idx;
    assign wr_data = cmd.slot_dec ? (rd_data_reg - 8'd1) : reload_reg;

    always_comb begin
        out_load   = cmd.item_go || cmd.slot_kill || cmd.emit_done;
        res_status = hlt_pkg::ST_DONE;
        res_node   = 5'd0;
        res_last   = 1'b1;
        priority if (cmd.item_go) begin
            res_status = item_ok ? hlt_pkg::ST_ACCEPTED : hlt_pkg::ST_NOT_REG;
            res_node   = node_id;
        end else if (cmd.slot_kill) begin
            res_status = hlt_pkg::ST_DIED;
            res_node   = idx_wide[4:0];
            res_last   = 1'b0;
        end else begin
            res_status = hlt_pkg::ST_DONE;
        end
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg    <= hlt_pkg::RELOAD_RESET;
            live_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                reload_reg <= cfg_wr_data;
            end
            live_reg      <= live_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_status_reg <= res_status;
            out_node_reg   <= res_node;
            out_last_reg   <= res_last;
        end
    end

    // count memory, registered read at the sweep pointer
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cnt_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= cnt_mem[idx_reg];
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_node   = out_node_reg;
    assign out_last   = out_last_reg;

endmodule

// ===== sv/heartbeat_liveness_table.sv =====
// Channel   | Dir | Handshake         | Payload
// ----------+-----+-------------------+------------------------------------------
// request   | in  | s_tvalid/s_tready | s_tuser[1:0]=req_type, s_tdata[4:0]=node_id
// result    | out | m_tvalid/m_tready | m_tuser[1:0]=status, m_tdata[4:0]=node_ref,
//           |     |                   | m_tlast=last
// config    | in  | cfg_wr_en         | cfg_wr_data[7:0]=reload_count
//
// Heartbeat and register transactions go straight to the output register:
// one per cycle while m_tready stays high.
// A period tick walks every slot through the count memory's single read
// port, reading each count (S_READ) and then evaluating it (S_EVAL), then
// posts done. s_tready is low for the whole sweep.
// A died result waiting on m_tready halts the sweep at that slot.
// Reset (aresetn low, synchronous) clears the live flags, the sweep state
// and the output valid, and sets reload_count to 5. No clearing pass.
//
// Top level: hooks the controller to the datapath. Depends on hlt_pkg,
// hlt_ctrl and hlt_datapath.
module heartbeat_liveness_table #(
    parameter int NODE_SLOTS = hlt_pkg::NODE_SLOTS_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,   // reload_count
    // request stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // [4:0] node_id, [7:5] zero
    input  logic [1:0] s_tuser,       // [1:0] req_type
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,       // [4:0] node_ref, [7:5] zero
    output logic [1:0] m_tuser,       // [1:0] status
    output logic       m_tlast
);

    hlt_pkg::cmd_t  cmd;
    hlt_pkg::stat_t stat;
    logic [4:0]     node_ref;

    // Sequencing: one transaction per cycle in idle while the result register is free, slot walk on tick.
    hlt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .req_type (s_tuser),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Storage and result formation.
    hlt_datapath #(
        .NODE_SLOTS (NODE_SLOTS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_type    (s_tuser),
        .node_id     (s_tdata[4:0]),
        .cmd         (cmd),
        .stat        (stat),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_status  (m_tuser),
        .out_node    (node_ref),
        .out_last    (m_tlast)
    );

    assign m_tdata = {3'b000, node_ref};

endmodule
